// ===== sv/rgbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbs_pkg
// Types, widths and constants shared by the rgb sum limited scaler files.
// ----------------------------------------------------------------------------
package rgbs_pkg;

  localparam int SLOT_W  = 2;
  localparam int CHAN_W  = 8;
  localparam int LVL_W   = 10;
  localparam int SCL_W   = 18;   // scaled channel, Q.8
  localparam int SUM_W   = 20;   // sum of three scaled channels, Q.8
  localparam int PROD_W  = 36;   // scaled channel times kept sum
  localparam int NUM_W   = 28;   // dividend after dropping the 256 factor
  localparam int NCHAN   = 3;

  localparam logic [SCL_W-1:0] SCALE_INT = SCL_W'(1027);   // floor(1023*256/255)
  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(261888); // 1023 * 256
  localparam logic [SUM_W-1:0] FRAC_ONE  = SUM_W'(256);

  localparam logic [CHAN_W-1:0] THIRD_1 = CHAN_W'(85);
  localparam logic [CHAN_W-1:0] THIRD_2 = CHAN_W'(170);
  localparam logic [CHAN_W-1:0] THIRD_3 = CHAN_W'(255);

  // item moving through the divider pipeline
  typedef struct packed {
    logic [SLOT_W-1:0]             slot;
    logic [SUM_W-1:0]              den;
    logic [NCHAN-1:0][NUM_W-1:0]   rem;
    logic [NCHAN-1:0][LVL_W-1:0]   quo;
  } div_item_t;

  // floor(1023*256*x/255) = 1027*x + floor(x/85)
  function automatic logic [SCL_W-1:0] scale_chan(input logic [CHAN_W-1:0] x);
    logic [SCL_W-1:0] xe;
    logic [SCL_W-1:0] q;
    begin
      xe = SCL_W'(x);
      q  = SCL_W'(x >= THIRD_1) + SCL_W'(x >= THIRD_2) + SCL_W'(x >= THIRD_3);
      scale_chan = (xe << 10) + (xe << 1) + xe + q;
    end
  endfunction

endpackage

// ===== sv/rgbs_if.sv =====
// ----------------------------------------------------------------------------
// rgbs_if
// Valid/ready channels for color requests and scaled drive levels.
// ----------------------------------------------------------------------------
interface rgbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [rgbs_pkg::SLOT_W-1:0]    slot;
  logic [rgbs_pkg::CHAN_W-1:0]    red_in;
  logic [rgbs_pkg::CHAN_W-1:0]    green_in;
  logic [rgbs_pkg::CHAN_W-1:0]    blue_in;

  modport source (output valid, slot, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, slot, red_in, green_in, blue_in, output ready);
endinterface

interface rgbs_out_if;
  logic                           valid;
  logic                           ready;
  logic [rgbs_pkg::SLOT_W-1:0]    slot_out;
  logic [rgbs_pkg::LVL_W-1:0]     red_level;
  logic [rgbs_pkg::LVL_W-1:0]     green_level;
  logic [rgbs_pkg::LVL_W-1:0]     blue_level;

  modport source (output valid, slot_out, red_level, green_level, blue_level,
                  input ready);
  modport sink   (input valid, slot_out, red_level, green_level, blue_level,
                  output ready);
endinterface

// ===== sv/rgb_sum_limited_scaler.sv =====
// ----------------------------------------------------------------------------
// rgb_sum_limited_scaler
// Scales 8-bit red, green and blue to 10-bit drive levels and, when the total
// exceeds full scale, cuts every channel by its share of the excess.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while out_ch.ready is not held low; set by
//   the 14-stage pipeline whose last ten stages each resolve one quotient
//   bit of the limiting division
// each stage holds its item until the next one frees, so a stalled output
//   still lets upstream bubbles fill
// reset: synchronous, active low; clears the valid bit of every stage
// ----------------------------------------------------------------------------
module rgb_sum_limited_scaler (
  input  logic              clk,
  input  logic              rst_n,
  rgbs_in_if.sink           in_ch,
  rgbs_out_if.source        out_ch
);
  import rgbs_pkg::*;

  localparam int NDIV = LVL_W;

  // stage 1: scaled channels
  logic                          v1_r;
  logic [SLOT_W-1:0]             slot1_r;
  logic [NCHAN-1:0][SCL_W-1:0]   s1_r;
  // stage 2: sum
  logic                          v2_r;
  logic [SLOT_W-1:0]             slot2_r;
  logic [NCHAN-1:0][SCL_W-1:0]   s2_r;
  logic [SUM_W-1:0]              sum2_r;
  // stage 3: products with the kept sum
  logic                          v3_r;
  logic [SLOT_W-1:0]             slot3_r;
  logic [NCHAN-1:0][SCL_W-1:0]   s3_r;
  logic [NCHAN-1:0][PROD_W-1:0]  prod3_r;
  logic [SUM_W-1:0]              sum3_r;
  logic                          lim3_r;
  // stage 4: dividend and divisor
  logic                          v4_r;
  div_item_t                     item4_r;
  div_item_t                     item4_nxt;

  logic rdy1, rdy2, rdy3, rdy4;
  logic [NDIV:0]                 div_rdy;
  logic [NDIV:0]                 div_v;
  div_item_t                     div_item [NDIV+1];

  logic [SUM_W-1:0]              sum_nxt;
  logic [SUM_W-1:0]              kept;

  // stage ready chain: a stage takes a new item when empty or draining
  assign rdy1 = !v1_r || rdy2;
  assign rdy2 = !v2_r || rdy3;
  assign rdy3 = !v3_r || rdy4;
  assign rdy4 = !v4_r || div_rdy[0];
  assign in_ch.ready = rdy1;

  // stage 1: scale to Q.8 drive range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      slot1_r  <= in_ch.slot;
      s1_r[0]  <= scale_chan(in_ch.red_in);
      s1_r[1]  <= scale_chan(in_ch.green_in);
      s1_r[2]  <= scale_chan(in_ch.blue_in);
    end
  end

  // stage 2: total drive
  assign sum_nxt = SUM_W'(s1_r[0]) + SUM_W'(s1_r[1]) + SUM_W'(s1_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      slot2_r <= slot1_r;
      s2_r    <= s1_r;
      sum2_r  <= sum_nxt;
    end
  end

  // stage 3: kept = S - 256*E = 1023*256 + (S mod 256)
  assign kept = SUM_LIMIT + SUM_W'(sum2_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      slot3_r <= slot2_r;
      s3_r    <= s2_r;
      sum3_r  <= sum2_r;
      lim3_r  <= (sum2_r > SUM_LIMIT);
      for (int c = 0; c < NCHAN; c++) begin
        prod3_r[c] <= PROD_W'(s2_r[c]) * PROD_W'(kept);
      end
    end
  end

  // stage 4: limited path divides product/256 by S, otherwise s by 256
  always_comb begin
    item4_nxt.slot = slot3_r;
    item4_nxt.den  = lim3_r ? sum3_r : FRAC_ONE;
    for (int c = 0; c < NCHAN; c++) begin
      item4_nxt.rem[c] = lim3_r ? prod3_r[c][PROD_W-1:8] : NUM_W'(s3_r[c]);
      item4_nxt.quo[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      item4_r <= item4_nxt;
    end
  end

  // division pipeline, most significant quotient bit first
  assign div_v[0]    = v4_r;
  assign div_item[0] = item4_r;
  assign div_rdy[NDIV] = out_ch.ready;

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    assign div_rdy[j] = !div_v[j+1] || div_rdy[j+1];

    rgbs_div_stage #(
      .BIT (NDIV - 1 - j)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (div_rdy[j]),
      .valid_in  (div_v[j]),
      .item_in   (div_item[j]),
      .valid_out (div_v[j+1]),
      .item_out  (div_item[j+1])
    );
  end

  // result
  assign out_ch.valid       = div_v[NDIV];
  assign out_ch.slot_out    = div_item[NDIV].slot;
  assign out_ch.red_level   = div_item[NDIV].quo[0];
  assign out_ch.green_level = div_item[NDIV].quo[1];
  assign out_ch.blue_level  = div_item[NDIV].quo[2];

endmodule

// ===== sv/rgbs_div_stage.sv =====
// ----------------------------------------------------------------------------
// rgbs_div_stage
// One registered restoring-division step: resolves one quotient bit for all
// three channels against the shared divisor.
// ----------------------------------------------------------------------------
module rgbs_div_stage #(
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                valid_in,
  input  rgbs_pkg::div_item_t item_in,
  output logic                valid_out,
  output rgbs_pkg::div_item_t item_out
);
  import rgbs_pkg::*;

  localparam int CMP_W = NUM_W + 2;

  logic      valid_r;
  div_item_t item_r;
  div_item_t item_nxt;
  logic [CMP_W-1:0] den_sh;

  // shifted divisor for this bit
  assign den_sh = CMP_W'(item_in.den) << BIT;

  // compare and subtract per channel
  always_comb begin
    item_nxt = item_in;
    for (int c = 0; c < NCHAN; c++) begin
      if (CMP_W'(item_in.rem[c]) >= den_sh) begin
        item_nxt.rem[c]      = NUM_W'(CMP_W'(item_in.rem[c]) - den_sh);
        item_nxt.quo[c][BIT] = 1'b1;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

  assign valid_out = valid_r;
  assign item_out  = item_r;

endmodule
